FILE: src/s5f_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s5f_pkg
// Shared types and constants for the symmetric 5x5 image filter.
// ----------------------------------------------------------------------------
package s5f_pkg;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned ROW_W   = 12;
    localparam int unsigned COL_W   = 11;
    localparam int unsigned COEF_W  = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_A_W = 3;

    // register indexes
    localparam logic [CFG_A_W-1:0] REG_CENTER   = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_EDGE     = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_DIAGONAL = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_AXIS_TWO = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_KNIGHT   = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_CORNER   = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_WIDTH    = 3'd6;
    localparam logic [CFG_A_W-1:0] REG_HEIGHT   = 3'd7;

    localparam int unsigned NUM_CLASS = 6;
    // sum of up to eight pixels fits in 11 bits
    localparam int unsigned CSUM_W = 11;
    // product 16x11 signed plus growth over six terms
    localparam int unsigned PROD_W = 28;
    localparam int unsigned ACC_W  = 31;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [PIX_W-1:0]         t_pix;

    // one front-end classified item, queued for the back end
    typedef struct packed {
        logic              do_filt;
        logic              do_copy;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        t_pix              pix;
        t_pix [24:0]       win;
    } t_job;

    // payload of one result transfer
    typedef struct packed {
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        t_pix             out_value;
        logic             last;
    } t_result;

    typedef struct packed {
        t_pix pixel;
        logic start_of_frame;
    } t_pixel_in;

endpackage
`default_nettype wire

FILE: src/s5f_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s5f_stream_if
// Valid/ready channel carrying a payload of type T.
// ----------------------------------------------------------------------------
interface s5f_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: src/symmetric_5x5_image_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// symmetric_5x5_image_filter
// Streaming 5x5 filter with six symmetric weight classes over a raster image.
// ----------------------------------------------------------------------------
// Usage: pixels enter on s_in (pixel, start_of_frame) in raster order; results
// leave on m_out (out_row, out_col, out_value, last). A pixel within two of
// a border is copied out; an interior pixel is emitted once the pixel two rows
// and two columns later arrives, ahead of any copy due on the same input.
// Registers are to be written through i_cfg_we/i_cfg_idx/i_cfg_data only
// while idle; the block does not enforce it. One pixel is taken per cycle
// while s_in.ready is high. Each passes the line-store read, class sums,
// products, then the result queue; a filtered result precedes its copy.
// The queue is eight deep; s_in.ready drops when it nears full, so a stalled
// receiver back-pressures the source without losing results.
// Reset clears position, window, queue and restores the register defaults;
// the line store is not cleared.
// ----------------------------------------------------------------------------
module symmetric_5x5_image_filter #(
    parameter int unsigned MAX_WIDTH = 2048,
    parameter int unsigned OUT_SHIFT = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [s5f_pkg::CFG_A_W-1:0]   i_cfg_idx,
    input  wire logic [s5f_pkg::CFG_W-1:0]     i_cfg_data,
    s5f_stream_if.sink                         s_in,
    s5f_stream_if.source                       m_out
);
    s5f_pkg::t_coef [5:0] r_coef;
    logic [s5f_pkg::ROW_W-1:0] r_width, r_height;
    s5f_pkg::t_job job;
    logic space, adv;

    // configuration registers; center weight resets to one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef   <= {{5{16'sd0}}, 16'sd1};
            r_width  <= 12'd640;
            r_height <= 12'd480;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                s5f_pkg::REG_WIDTH:  r_width  <= i_cfg_data[s5f_pkg::ROW_W-1:0];
                s5f_pkg::REG_HEIGHT: r_height <= i_cfg_data[s5f_pkg::ROW_W-1:0];
                default:             r_coef[i_cfg_idx] <= i_cfg_data;
            endcase
        end
    end

    assign s_in.ready = space;
    assign adv = s_in.valid & space;

    s5f_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv), .i_in(s_in.payload),
        .i_width(r_width), .i_height(r_height), .o_job(job)
    );

    s5f_back #(.OUT_SHIFT(OUT_SHIFT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job(job), .i_coef(r_coef),
        .o_space(space), .m_out(m_out)
    );
endmodule
`default_nettype wire

FILE: src/s5f_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s5f_front
// Tracks position, keeps the line store and window, classifies each pixel.
// ----------------------------------------------------------------------------
module s5f_front #(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_adv,
    input  wire s5f_pkg::t_pixel_in        i_in,
    input  wire logic [s5f_pkg::ROW_W-1:0] i_width,
    input  wire logic [s5f_pkg::ROW_W-1:0] i_height,
    output s5f_pkg::t_job                  o_job
);
    localparam int unsigned AW = $clog2(MAX_WIDTH);

    logic [s5f_pkg::ROW_W-1:0] r_row, n_row, w_eff, h_eff, cur_r, nr;
    logic [s5f_pkg::ROW_W:0]   r_col, n_col, cur_c, nc;
    logic [s5f_pkg::PIX_W-1:0] bank_q [0:3];
    logic [s5f_pkg::PIX_W-1:0] rd_col [0:3];
    logic [s5f_pkg::PIX_W-1:0] r_win [0:4][0:4];
    logic [s5f_pkg::PIX_W-1:0] n_win [0:4][0:4];
    logic [AW-1:0] rw_a;

    // stage registers aligned with the line reads
    logic r_vld, r_filt, r_copy;
    logic [s5f_pkg::ROW_W-1:0] r_r;
    logic [s5f_pkg::COL_W-1:0] r_c;
    logic [s5f_pkg::PIX_W-1:0] r_pix;

    // effective frame size
    always_comb begin
        w_eff = i_width;
        if (w_eff == '0) w_eff = 12'd1;
        if (32'(w_eff) > 32'(MAX_WIDTH))
            w_eff = s5f_pkg::ROW_W'(MAX_WIDTH);
        h_eff = (i_height == '0) ? 12'd1 : i_height;
    end

    // position of this pixel and the next
    always_comb begin
        cur_r = r_row;
        cur_c = r_col;
        if (i_in.start_of_frame) begin
            cur_r = '0;
            cur_c = '0;
        end
        if (cur_c >= {1'b0, w_eff}) begin
            cur_c = '0;
            cur_r = cur_r + 1'b1;
        end
        if (cur_r >= h_eff) cur_r = '0;
        nc = cur_c + 1'b1;
        nr = cur_r;
        if (nc >= {1'b0, w_eff}) begin
            nc = '0;
            nr = cur_r + 1'b1;
            if (nr >= h_eff) nr = '0;
        end
        n_row = nr;
        n_col = nc;
        rw_a = cur_c[AW-1:0];
    end

    // line store: one bank per row modulo four, each read once and
    // written at most once per transfer, both at the current column
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [s5f_pkg::PIX_W-1:0] r_mem [0:MAX_WIDTH-1];
        logic [s5f_pkg::PIX_W-1:0] r_q;
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_q <= r_mem[rw_a];
                if (cur_r[1:0] == 2'(b)) r_mem[rw_a] <= i_in.pixel;
            end
        end
        assign bank_q[b] = r_q;
    end

    // fresh column: window row i comes from bank (row + i) mod 4
    always_comb begin
        for (int i = 0; i < 4; i++)
            rd_col[i] = bank_q[2'(r_r[1:0] + 2'(i))];
    end

    // window shift; the fresh column comes from the registered line reads,
    // so the window is aligned one pixel late; the job output patches it in
    always_comb begin
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 5; j++)
                n_win[i][j] = r_win[i][j];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_adv) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // window holds columns older than the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++)
                for (int j = 0; j < 5; j++)
                    r_win[i][j] <= '0;
        end else if (r_vld) begin
            for (int i = 0; i < 5; i++)
                for (int j = 0; j < 4; j++)
                    r_win[i][j] <= n_win[i][j+1];
            for (int i = 0; i < 4; i++)
                r_win[i][4] <= rd_col[i];
            r_win[4][4] <= r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 1'b0;
        else          r_vld <= i_adv;
        if (i_adv) begin
            r_pix  <= i_in.pixel;
            r_filt <= (cur_r >= 12'd4) && (cur_c >= 13'd4);
            r_copy <= (cur_r < 12'd2) || ({1'b0, cur_r} + 13'd2 >= {1'b0, h_eff})
                      || (cur_c < 13'd2) || (cur_c + 13'd2 >= {1'b0, w_eff});
            r_r    <= cur_r;
            r_c    <= cur_c[s5f_pkg::COL_W-1:0];
        end
    end

    // job as seen once the current column is in place
    always_comb begin
        o_job.do_filt = r_vld & r_filt;
        o_job.do_copy = r_vld & r_copy;
        o_job.row     = r_r - 12'd2;
        o_job.col     = r_c - 11'd2;
        o_job.pix     = r_pix;
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 4; j++)
                o_job.win[i*5+j] = r_win[i][j+1];
        for (int i = 0; i < 4; i++)
            o_job.win[i*5+4] = rd_col[i];
        o_job.win[24] = r_pix;
    end
endmodule
`default_nettype wire

FILE: src/s5f_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s5f_back
// Queue of classified jobs, filter arithmetic and result sequencing.
// ----------------------------------------------------------------------------
module s5f_back #(
    parameter int unsigned OUT_SHIFT = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire s5f_pkg::t_job               i_job,
    input  wire s5f_pkg::t_coef [5:0]        i_coef,
    output logic                             o_space,
    s5f_stream_if.source                     m_out
);
    localparam int unsigned QD = 8;
    localparam int unsigned QA = 3;

    // job summary captured into the queue: flags, position, pixel, weighted sum
    typedef struct packed {
        logic                       filt;
        logic                       copy;
        logic [s5f_pkg::ROW_W-1:0]  row;
        logic [s5f_pkg::COL_W-1:0]  col;
        s5f_pkg::t_pix              pix;
        logic signed [s5f_pkg::ACC_W-1:0] acc;
    } t_ent;

    // stage 1: class sums
    logic [s5f_pkg::CSUM_W-1:0] r_cs [0:5];
    logic r1_v, r1_f, r1_c;
    logic [s5f_pkg::ROW_W-1:0] r1_row;
    logic [s5f_pkg::COL_W-1:0] r1_col, dummy_c;
    s5f_pkg::t_pix r1_pix;
    function automatic logic [s5f_pkg::CSUM_W-1:0] px(input s5f_pkg::t_job j,
                                                      input int r, input int c);
        px = s5f_pkg::CSUM_W'(j.win[r*5+c]);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= i_job.do_filt | i_job.do_copy;
        r1_f   <= i_job.do_filt;
        r1_c   <= i_job.do_copy;
        r1_row <= i_job.row;
        r1_col <= i_job.col;
        r1_pix <= i_job.pix;
        r_cs[0] <= px(i_job,2,2);
        r_cs[1] <= px(i_job,1,2)+px(i_job,2,1)+px(i_job,2,3)+px(i_job,3,2);
        r_cs[2] <= px(i_job,1,1)+px(i_job,1,3)+px(i_job,3,1)+px(i_job,3,3);
        r_cs[3] <= px(i_job,0,2)+px(i_job,2,0)+px(i_job,2,4)+px(i_job,4,2);
        r_cs[4] <= px(i_job,0,1)+px(i_job,0,3)+px(i_job,1,0)+px(i_job,1,4)
                 + px(i_job,3,0)+px(i_job,3,4)+px(i_job,4,1)+px(i_job,4,3);
        r_cs[5] <= px(i_job,0,0)+px(i_job,0,4)+px(i_job,4,0)+px(i_job,4,4);
    end
    assign dummy_c = r1_col;

    // stage 2: six products
    logic signed [s5f_pkg::PROD_W-1:0] r_pr [0:5];
    logic r2_v, r2_f, r2_c;
    logic [s5f_pkg::ROW_W-1:0] r2_row;
    logic [s5f_pkg::COL_W-1:0] r2_col;
    s5f_pkg::t_pix r2_pix;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
        r2_f <= r1_f; r2_c <= r1_c; r2_row <= r1_row; r2_col <= dummy_c;
        r2_pix <= r1_pix;
        for (int k = 0; k < 6; k++)
            r_pr[k] <= s5f_pkg::PROD_W'(i_coef[k] * $signed({1'b0, r_cs[k]}));
    end

    // stage 3: accumulate into the queue
    t_ent q [0:QD-1];
    t_ent n_ent;
    logic [QA:0] r_cnt;
    logic [QA-1:0] r_wp, r_rp;
    logic r_half;  // filter part already sent for head entry
    logic pop, push;
    logic signed [s5f_pkg::ACC_W-1:0] sum;
    always_comb begin
        sum = '0;
        for (int k = 0; k < 6; k++) sum = sum + s5f_pkg::ACC_W'(r_pr[k]);
        n_ent = '{filt: r2_f, copy: r2_c, row: r2_row, col: r2_col,
                  pix: r2_pix, acc: sum};
    end
    assign push = r2_v;
    // three jobs in flight ahead of the queue
    assign o_space = (r_cnt <= (QA+1)'(QD - 4));

    t_ent hd;
    assign hd = q[r_rp];
    logic send_f;
    assign send_f = hd.filt & ~r_half;
    assign m_out.valid = (r_cnt != '0);
    always_comb begin
        logic signed [s5f_pkg::ACC_W-1:0] sh;
        sh = hd.acc >>> OUT_SHIFT;
        if (send_f) begin
            m_out.payload.out_row   = hd.row;
            m_out.payload.out_col   = hd.col;
            m_out.payload.out_value = sh[7:0];
            m_out.payload.last      = ~hd.copy;
        end else begin
            m_out.payload.out_row   = hd.row + 12'd2;
            m_out.payload.out_col   = hd.col + 11'd2;
            m_out.payload.out_value = hd.pix;
            m_out.payload.last      = 1'b1;
        end
    end
    assign pop = m_out.valid & m_out.ready & m_out.payload.last;

    always_ff @(posedge i_clk) begin
        if (push) q[r_wp] <= n_ent;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_wp <= '0; r_rp <= '0; r_half <= 1'b0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QA+1)'(push) - (QA+1)'(pop);
            if (pop) r_half <= 1'b0;
            else if (m_out.valid & m_out.ready) r_half <= 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == (QA+1)'(QD) |-> !push || pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> !pop) else $error("queue underflow");
    a_half_only_dual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half && r_cnt != '0 |-> hd.filt && hd.copy) else $error("bad split");
`endif
endmodule
`default_nettype wire
